@@ sv/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int PRIO_BITS = 8;
    localparam int TAG_BITS  = 8;
    localparam int OCC_BITS  = 5;
    localparam int STAT_BITS = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                 kind;
        logic [PRIO_BITS-1:0] priority_req;
        logic [TAG_BITS-1:0]  item_tag;
    } t_item;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic                 out_valid;
        logic [PRIO_BITS-1:0] out_priority;
        logic [TAG_BITS-1:0]  out_tag;
        logic [OCC_BITS-1:0]  occupancy;
    } t_result;

    typedef struct packed {
        logic                 ins;
        logic                 pop;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } t_cell_ctrl;

endpackage
`default_nettype wire

@@ sv/sorted_priority_queue_unit.sv @@
// Top level of the sorted priority queue: cell chain, entry count and result register.
// The queue takes one item (insert or pop) in every clock cycle; busy stays low. Every
// accepted item gives exactly one result, shown on o_result with o_strobe high for one
// cycle, the cycle after the item was accepted; the receiver must take it in that cycle,
// since results cannot be held off. The cell chain compares all slots against the new
// priority and shifts the entries of all slots together.
// Equal priorities leave in arrival order. An insert into a full queue is refused with
// status full; a pop on an empty queue returns status empty.
`default_nettype none
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_item i_item,
    output logic       o_strobe,
    output t_result    o_result
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_strobe;
    t_result              r_result;
    t_result              n_result;
    t_cell_ctrl           w_ctrl;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic [DEPTH-1:0]     w_valid;
    logic [DEPTH-1:0]     w_before;
    logic [PRIO_BITS-1:0] w_prio [DEPTH];
    logic [TAG_BITS-1:0]  w_tag  [DEPTH];
    logic [CW+OCC_BITS-1:0] w_occ;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_ctrl.ins  = w_accept && (i_item.kind == KIND_INSERT) && !w_full;
    assign w_ctrl.pop  = w_accept && (i_item.kind == KIND_POP) && !w_empty;
    assign w_ctrl.prio = i_item.priority_req;
    assign w_ctrl.tag  = i_item.item_tag;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 w_lb;
        logic [PRIO_BITS-1:0] w_lp;
        logic [TAG_BITS-1:0]  w_lt;
        logic [PRIO_BITS-1:0] w_rp;
        logic [TAG_BITS-1:0]  w_rt;

        assign w_valid[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_lb = 1'b0;
            assign w_lp = '0;
            assign w_lt = '0;
        end else begin : g_mid
            assign w_lb = w_before[g-1];
            assign w_lp = w_prio[g-1];
            assign w_lt = w_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_rp = '0;
            assign w_rt = '0;
        end else begin : g_body
            assign w_rp = w_prio[g+1];
            assign w_rt = w_tag[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_valid      (w_valid[g]),
            .i_left_before(w_lb),
            .i_left_prio  (w_lp),
            .i_left_tag   (w_lt),
            .i_right_prio (w_rp),
            .i_right_tag  (w_rt),
            .o_before     (w_before[g]),
            .o_prio       (w_prio[g]),
            .o_tag        (w_tag[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_occ = {{OCC_BITS{1'b0}}, n_count};

    always_comb begin
        n_result              = '0;
        n_result.occupancy    = w_occ[OCC_BITS-1:0];
        unique case (i_item.kind)
            KIND_INSERT: begin
                n_result.status = w_full ? ST_FULL : ST_OK;
            end
            KIND_POP: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    n_result.status       = ST_OK;
                    n_result.out_valid    = 1'b1;
                    n_result.out_priority = w_prio[0];
                    n_result.out_tag      = w_tag[0];
                end
            end
            default: n_result.status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= w_accept;
        end
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_strobe)
        else $error("accepted item without result");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_prio[0] <= w_prio[1]))
        else $error("head entries out of order");

    a_pop_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.out_valid) |-> (o_result.status == ST_OK))
        else $error("popped entry with bad status");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.ins && !$past(!i_rst_n)) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");
`endif

endmodule
`default_nettype wire

@@ sv/spq_cell.sv @@
// One slot of the sorted chain: holds an entry, shifts right on insert, left on pop.
`default_nettype none
module spq_cell
    import spq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_cell_ctrl           i_ctrl,
    input  wire logic                 i_valid,
    input  wire logic                 i_left_before,
    input  wire logic [PRIO_BITS-1:0] i_left_prio,
    input  wire logic [TAG_BITS-1:0]  i_left_tag,
    input  wire logic [PRIO_BITS-1:0] i_right_prio,
    input  wire logic [TAG_BITS-1:0]  i_right_tag,
    output logic                      o_before,
    output logic [PRIO_BITS-1:0]      o_prio,
    output logic [TAG_BITS-1:0]       o_tag
);

    logic [PRIO_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]  r_tag;
    logic [PRIO_BITS-1:0] n_prio;
    logic [TAG_BITS-1:0]  n_tag;

    // new entry goes ahead of this slot if the slot is empty or strictly less urgent
    assign o_before = !i_valid || (r_prio > i_ctrl.prio);

    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_ctrl.ins) begin
            if (i_left_before) begin
                n_prio = i_left_prio;
                n_tag  = i_left_tag;
            end else if (o_before) begin
                n_prio = i_ctrl.prio;
                n_tag  = i_ctrl.tag;
            end
        end else if (i_ctrl.pop) begin
            n_prio = i_right_prio;
            n_tag  = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_prio = r_prio;
    assign o_tag  = r_tag;

endmodule
`default_nettype wire
